// ----- src/cocl_pkg.sv -----
package cocl_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 9;
    localparam int KIND_W     = 2;
    localparam int MASK_W     = 4;
    localparam int WORD_W     = 2 * ROW_W + 1;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 5;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_CLIP  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    localparam logic [MASK_W-1:0] MASK_NONE  = 4'b0000;
    localparam logic [MASK_W-1:0] MASK_UPPER = 4'b0101;
    localparam logic [MASK_W-1:0] MASK_LOWER = 4'b1010;
    localparam logic [MASK_W-1:0] MASK_FULL  = 4'b1111;

    typedef logic signed [ROW_W-1:0] t_row;

    typedef struct packed {
        logic load_item;
        logic finish;
        logic sweep_step;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic item_clear;
        logic sweep_done;
    } t_dp_stat;

    function automatic t_row f_min(input t_row a, input t_row b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_row f_max(input t_row a, input t_row b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- src/cocl_ctrl.sv -----
module cocl_ctrl
    import cocl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_cmd.load_item   = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.finish      = (r_state == S_CALC) && i_stat.slot_free;
    assign o_cmd.sweep_step  = (r_state == S_SWEEP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                // a clear beat sweeps the store once its result goes to the output register
                if (i_stat.slot_free) begin
                    n_state = i_stat.item_clear ? S_SWEEP : S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/cocl_dp.sv -----
module cocl_dp
    import cocl_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [OUT_USER_W-1:0] o_out_user
);

    localparam int AW = $clog2(SCREEN_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SCREEN_WIDTH - 1);
    localparam logic [WORD_W-1:0] RESET_WORD =
        {1'b0, ROW_W'(0), ROW_W'(SCREEN_HEIGHT - 1)};

    logic [WORD_W-1:0] mem [SCREEN_WIDTH];

    logic              r_cmd;
    logic [KIND_W-1:0] r_kind;
    logic [COL_W-1:0]  r_col;
    t_row              r_wt;
    t_row              r_wb;
    t_row              r_cp;
    t_row              r_fp;
    logic [WORD_W-1:0] r_rd;
    logic [AW-1:0]     r_sweep_addr;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [COL_W+AW-1:0] in_col_ext;
    logic [COL_W+AW-1:0] r_col_ext;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                wr_en;

    t_row        lim_top;
    t_row        lim_bot;
    logic        covered;
    logic        col_ok;
    logic        kind_ok;
    logic        clip_ok;
    t_row        top;
    t_row        bot;
    t_row        new_top;
    t_row        new_bot;
    t_row        cbot;
    t_row        ftop;
    logic        new_cov;
    logic [MASK_W-1:0] mask;
    t_row        o_top;
    t_row        o_bot;
    t_row        o_ctop;
    t_row        o_fbot;
    t_row        o_cbot;
    t_row        o_ftop;

    assign in_col_ext = (COL_W + AW)'(i_in_data[COL_W-1:0]);
    assign r_col_ext  = (COL_W + AW)'(r_col);
    assign rd_addr    = in_col_ext[AW-1:0];

    assign lim_top = r_rd[ROW_W-1:0];
    assign lim_bot = r_rd[2*ROW_W-1:ROW_W];
    assign covered = r_rd[WORD_W-1];

    assign col_ok  = (r_col_ext < (COL_W + AW)'(SCREEN_WIDTH));
    assign kind_ok = (r_kind == KIND_UPPER) || (r_kind == KIND_LOWER)
                  || (r_kind == KIND_FULL);
    assign clip_ok = (r_cmd == CMD_CLIP) && col_ok && kind_ok && !covered;

    always_comb begin
        top     = '0;
        bot     = '0;
        new_top = lim_top;
        new_bot = lim_bot;
        new_cov = covered;
        cbot    = '0;
        ftop    = '0;
        mask    = MASK_NONE;
        case (r_kind)
            KIND_UPPER: begin
                top     = f_min(r_wt, lim_top);
                bot     = f_min(r_wb, lim_top);
                new_top = f_min(top, bot);
                cbot    = f_min(r_cp, top);
                mask    = MASK_UPPER;
            end
            KIND_LOWER: begin
                top     = f_max(r_wt, lim_bot);
                bot     = f_max(r_wb, lim_bot);
                new_bot = f_max(top, bot);
                ftop    = f_max(r_fp, bot);
                mask    = MASK_LOWER;
            end
            KIND_FULL: begin
                top     = f_min(r_wt, lim_top);
                bot     = f_max(r_wb, lim_bot);
                new_top = top;
                new_bot = bot;
                new_cov = 1'b1;
                cbot    = r_cp;
                ftop    = r_fp;
                mask    = MASK_FULL;
            end
            default: begin
                mask = MASK_NONE;
            end
        endcase
        if (!clip_ok) begin
            mask = MASK_NONE;
        end
        o_top  = clip_ok ? top : '0;
        o_bot  = clip_ok ? bot : '0;
        o_ctop = mask[0] ? lim_top : '0;
        o_fbot = mask[1] ? lim_bot : '0;
        o_cbot = mask[2] ? cbot : '0;
        o_ftop = mask[3] ? ftop : '0;
    end

    assign wr_en   = i_cmd.sweep_step || (i_cmd.finish && clip_ok);
    assign wr_addr = i_cmd.sweep_step ? r_sweep_addr : r_col_ext[AW-1:0];
    assign wr_data = i_cmd.sweep_step ? RESET_WORD : {new_cov, new_bot, new_top};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.load_item) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_in_user[0];
            r_kind <= i_in_user[2:1];
            r_col  <= i_in_data[8:0];
            r_wt   <= i_in_data[20:9];
            r_wb   <= i_in_data[32:21];
            r_cp   <= i_in_data[44:33];
            r_fp   <= i_in_data[56:45];
        end
        if (i_cmd.finish) begin
            r_out_data <= {7'd0, o_ftop, o_cbot, o_fbot, o_ctop, o_bot, o_top, r_col};
            r_out_user <= {mask, clip_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sweep_step) begin
                r_sweep_addr <= (r_sweep_addr == LAST_ADDR) ? '0 : r_sweep_addr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.slot_free  = !r_out_valid || i_out_ready;
    assign o_stat.item_clear = (r_cmd == CMD_CLEAR);
    assign o_stat.sweep_done = i_cmd.sweep_step && (r_sweep_addr == LAST_ADDR);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

`ifndef SYNTHESIS
    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending beat");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_item |-> (!i_cmd.finish && !i_cmd.sweep_step))
        else $error("item taken while store busy");

    a_load_then_finish_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_item |=> !i_cmd.load_item)
        else $error("two items taken back to back");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");
`endif

endmodule

// ----- src/column_occlusion_clipper_top.sv -----
// channel | dir | tdata (low bit up)                               | tuser (low bit up)
// s       | in  | column, wall_top_y, wall_bottom_y,                | command, segment_kind
//         |     | ceiling_plane_y, floor_plane_y                    |
// m       | out | span_column, span_top_row, span_bottom_row,       | draw_span,
//         |     | ceiling_top_out, floor_bottom_out,                | plane_write_mask
//         |     | ceiling_bottom_out, floor_top_out                 |
//
// each beat takes two steps: one to read the column word from the single-port store,
// one to clip, write the word back and load the output register
// after reset and after each clear beat every store word is swept back to its reset value,
// with o_s_tready low
// the output register lets a new beat in while a result waits; a stalled master
// side holds the next result in the update cycle until the register frees up
module column_occlusion_clipper_top
    import cocl_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // column, wall_top_y, wall_bottom_y, ceiling_plane_y, floor_plane_y
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // command, segment_kind
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // span_column, span_top_row, span_bottom_row, ceiling_top_out,
    // floor_bottom_out, ceiling_bottom_out, floor_top_out
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // draw_span, plane_write_mask
    output logic [OUT_USER_W-1:0] o_m_tuser
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cocl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    cocl_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (i_s_tdata),
        .i_in_user   (i_s_tuser),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

endmodule
